// ----- hdl/lcg_slice_descrambler_defines.svh -----
// Assertion helpers for the descrambler
`ifndef LCG_SLICE_DESCRAMBLER_DEFINES_SVH
`define LCG_SLICE_DESCRAMBLER_DEFINES_SVH

// same-cycle implication
`define LSD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/lsd_pkg.sv -----
package lsd_pkg;

	localparam int SIZE_W        = 24;
	localparam int MAP_AW        = 16;
	localparam int LOG_SLICE     = 5;
	localparam int LOG_MAX_CHUNK = 21;

	localparam logic [14:0] LCG_MUL = 15'd2109;
	localparam logic [14:0] LCG_INC = 15'd9273;
	localparam logic [15:0] KEY_OFS = 16'hc000;

	typedef struct packed {
		logic load;
		logic step;
		logic mul;
	} lcg_ctrl_t;

endpackage

// ----- hdl/lsd_map_mem.sv -----
module lsd_map_mem #(
	parameter int DATA_W = 28,
	parameter int ADDR_W = 16
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr_a,
	input  logic [ADDR_W-1:0] rd_addr_b,
	output logic [DATA_W-1:0] rd_data_a,
	output logic [DATA_W-1:0] rd_data_b
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

// ----- hdl/lsd_lcg.sv -----
module lsd_lcg import lsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  lcg_ctrl_t   ctrl,
	input  logic [15:0] load_seed,
	input  logic [15:0] slice_idx,
	output logic [15:0] swap_idx
);

	logic [15:0] seed_q;
	logic [15:0] swap_idx_q;
	logic [14:0] seed_next;
	logic [15:0] key;
	logic [31:0] prod;

	// only the low 15 bits survive the mask, so the step works on 15 bits
	assign seed_next = 15'(seed_q[14:0] * LCG_MUL + LCG_INC);
	assign key       = 16'({1'b0, seed_q[14:0]} + KEY_OFS);
	assign prod      = 32'(slice_idx) * 32'(key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q     <= '0;
			swap_idx_q <= '0;
		end else begin
			if (ctrl.load) begin
				seed_q <= load_seed;
			end else if (ctrl.step) begin
				seed_q <= {1'b0, seed_next};
			end
			if (ctrl.mul) begin
				swap_idx_q <= prod[31:16];
			end
		end
	end

	assign swap_idx = swap_idx_q;

endmodule

// ----- hdl/lcg_slice_descrambler.sv -----
// Descrambler for slice-shuffled binary images.
// Write image_size (image_size_we high for one cycle) while the block is idle;
// the write abandons any image in progress. Then feed the scrambled bytes on
// source_byte with source_valid/source_stall. Each accepted byte gives one
// result transaction on result_valid/result_stall: dest_offset, the byte
// unchanged, and image_done on the last byte of the image. Bytes past the end
// of an image start the same image again.
// Results are registered: one appears in the cycle after its byte is taken.
// In a 32-byte slice or a tail of fewer than 32 bytes a byte is taken every
// cycle unless the result side stalls. A slice start runs the map swap
// (generator step, key multiply, map read, two write-backs on the single map
// write port); a chunk start passes the planning state, an image start twice.
// The result register frees when its transaction completes, so a byte is
// taken in the same cycle that a stalled result is taken; while the receiver
// stalls with a result held, source_stall stays high.
// After reset, and again after every 2**EPOCH_W - 1 chunks, the map epoch tags
// are cleared in a pass over all 65536 map entries during which no byte is taken;
// image_size writes are taken during the pass.
module lcg_slice_descrambler import lsd_pkg::*; #(
	parameter int EPOCH_W = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              image_size_we,
	input  logic [SIZE_W-1:0] image_size,
	input  logic              source_valid,
	output logic              source_stall,
	input  logic [7:0]        source_byte,
	output logic              result_valid,
	input  logic              result_stall,
	output logic [SIZE_W-1:0] dest_offset,
	output logic [7:0]        data_byte,
	output logic              image_done
);

	`include "lcg_slice_descrambler_defines.svh"

	localparam int MEM_W = MAP_AW + EPOCH_W;

	typedef enum logic [9:0] {
		ST_CLEAR = 10'b0000000001,
		ST_PLAN  = 10'b0000000010,
		ST_ZERO  = 10'b0000000100,
		ST_TAIL  = 10'b0000001000,
		ST_LCG   = 10'b0000010000,
		ST_MUL   = 10'b0000100000,
		ST_RD    = 10'b0001000000,
		ST_WB1   = 10'b0010000000,
		ST_WB2   = 10'b0100000000,
		ST_BYTES = 10'b1000000000
	} state_t;

	state_t             state_q;
	logic [SIZE_W-1:0]  image_size_q;
	logic [SIZE_W-1:0]  bytes_left_q;
	logic [SIZE_W-1:0]  chunk_base_q;
	logic [4:0]         chunk_log_q;
	logic [MAP_AW-1:0]  slice_q;
	logic [4:0]         bis_q;
	logic [MAP_AW-1:0]  dest_slice_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [MAP_AW-1:0]  clr_cnt_q;
	logic [MAP_AW-1:0]  a_q;
	logic               result_valid_q;
	logic [SIZE_W-1:0]  dest_offset_q;
	logic [7:0]         data_byte_q;
	logic               image_done_q;

	logic              take_st;
	logic              out_free;
	logic              accept;
	logic              big;
	logic [4:0]        k_sel;
	logic [MAP_AW-1:0] swap_idx;
	lcg_ctrl_t         lcg_ctrl;
	logic              mem_wr_en;
	logic [MAP_AW-1:0] mem_wr_addr;
	logic [MEM_W-1:0]  mem_wr_data;
	logic [MEM_W-1:0]  rd_a;
	logic [MEM_W-1:0]  rd_b;
	logic [MAP_AW-1:0] map_a;
	logic [MAP_AW-1:0] map_b;
	logic [SIZE_W-1:0] dest_tail;
	logic [SIZE_W-1:0] dest_slice;

	assign take_st      = (state_q == ST_ZERO) || (state_q == ST_TAIL) || (state_q == ST_BYTES);
	assign out_free     = !result_valid_q || !result_stall;
	assign source_stall = !(take_st && out_free);
	assign accept       = source_valid && !source_stall;

	// largest power of two not above bytes_left, 32 B .. 2 MiB
	assign big = |bytes_left_q[SIZE_W-1:LOG_SLICE];
	always_comb begin
		k_sel = 5'(LOG_SLICE);
		for (int b = LOG_SLICE; b < LOG_MAX_CHUNK; b++) begin
			if (bytes_left_q[b]) begin
				k_sel = 5'(b);
			end
		end
		if (|bytes_left_q[SIZE_W-1:LOG_MAX_CHUNK]) begin
			k_sel = 5'(LOG_MAX_CHUNK);
		end
	end

	assign lcg_ctrl.load = (state_q == ST_PLAN) && (bytes_left_q == '0);
	assign lcg_ctrl.step = (state_q == ST_LCG);
	assign lcg_ctrl.mul  = (state_q == ST_MUL);

	lsd_lcg u_lcg (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (lcg_ctrl),
		.load_seed (image_size_q[15:0]),
		.slice_idx (slice_q),
		.swap_idx  (swap_idx)
	);

	// entries tagged with another epoch read as identity
	assign map_a = (rd_a[MEM_W-1:MAP_AW] == epoch_q) ? rd_a[MAP_AW-1:0] : slice_q;
	assign map_b = (rd_b[MEM_W-1:MAP_AW] == epoch_q) ? rd_b[MAP_AW-1:0] : swap_idx;

	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_addr = clr_cnt_q;
		mem_wr_data = '0;
		priority if (state_q == ST_CLEAR) begin
			mem_wr_en = 1'b1;
		end else if (state_q == ST_WB1) begin
			mem_wr_en   = 1'b1;
			mem_wr_addr = slice_q;
			mem_wr_data = {epoch_q, map_b};
		end else if (state_q == ST_WB2) begin
			mem_wr_en   = 1'b1;
			mem_wr_addr = swap_idx;
			mem_wr_data = {epoch_q, a_q};
		end else begin
			mem_wr_en = 1'b0;
		end
	end

	lsd_map_mem #(
		.DATA_W (MEM_W),
		.ADDR_W (MAP_AW)
	) u_map (
		.clk       (clk),
		.wr_en     (mem_wr_en),
		.wr_addr   (mem_wr_addr),
		.wr_data   (mem_wr_data),
		.rd_en     (state_q == ST_RD),
		.rd_addr_a (slice_q),
		.rd_addr_b (swap_idx),
		.rd_data_a (rd_a),
		.rd_data_b (rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			image_size_q <= '0;
			bytes_left_q <= '0;
			chunk_base_q <= '0;
			chunk_log_q  <= 5'(LOG_MAX_CHUNK);
			slice_q      <= '0;
			bis_q        <= '0;
			dest_slice_q <= '0;
			epoch_q      <= '0;
			clr_cnt_q    <= '0;
		end else begin
			if (image_size_we) begin
				image_size_q <= image_size;
			end
			if (image_size_we && state_q != ST_CLEAR) begin
				bytes_left_q <= '0;
				state_q      <= ST_PLAN;
			end else begin
				unique case (state_q)
					ST_CLEAR: begin
						clr_cnt_q <= clr_cnt_q + 1'b1;
						if (image_size_we) begin
							bytes_left_q <= '0;
						end
						if (clr_cnt_q == '1) begin
							state_q <= ST_PLAN;
						end
					end
					ST_PLAN: begin
						if (bytes_left_q == '0) begin
							bytes_left_q <= image_size_q;
							chunk_base_q <= '0;
							slice_q      <= '0;
							bis_q        <= '0;
							dest_slice_q <= '0;
							if (image_size_q == '0) begin
								state_q <= ST_ZERO;
							end
						end else if (!big) begin
							bis_q   <= '0;
							state_q <= ST_TAIL;
						end else if (epoch_q == '1) begin
							epoch_q   <= '0;
							clr_cnt_q <= '0;
							state_q   <= ST_CLEAR;
						end else begin
							epoch_q     <= epoch_q + 1'b1;
							chunk_log_q <= k_sel;
							slice_q     <= 16'((17'd1 << (k_sel - 5'(LOG_SLICE))) - 17'd1);
							bis_q       <= '0;
							state_q     <= ST_LCG;
						end
					end
					ST_ZERO: begin
						state_q <= ST_ZERO;
					end
					ST_TAIL: begin
						if (accept) begin
							bis_q        <= bis_q + 1'b1;
							bytes_left_q <= bytes_left_q - 1'b1;
							if (bytes_left_q == 24'd1) begin
								state_q <= ST_PLAN;
							end
						end
					end
					ST_LCG: begin
						state_q <= ST_MUL;
					end
					ST_MUL: begin
						state_q <= ST_RD;
					end
					ST_RD: begin
						state_q <= ST_WB1;
					end
					ST_WB1: begin
						dest_slice_q <= map_b;
						state_q      <= ST_WB2;
					end
					ST_WB2: begin
						state_q <= ST_BYTES;
					end
					ST_BYTES: begin
						if (accept) begin
							bis_q        <= bis_q + 1'b1;
							bytes_left_q <= bytes_left_q - 1'b1;
							if (bis_q == '1) begin
								if (slice_q == '0) begin
									chunk_base_q <= chunk_base_q + (24'd1 << chunk_log_q);
									state_q      <= ST_PLAN;
								end else begin
									slice_q <= slice_q - 1'b1;
									state_q <= ST_LCG;
								end
							end
						end
					end
					default: begin
						state_q <= ST_CLEAR;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WB1) begin
			a_q <= map_a;
		end
	end

	assign dest_tail  = chunk_base_q + 24'(bis_q);
	assign dest_slice = chunk_base_q + {3'b000, dest_slice_q, bis_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (accept) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_byte_q  <= source_byte;
			image_done_q <= (state_q == ST_ZERO) || (bytes_left_q == 24'd1);
			priority if (state_q == ST_ZERO) begin
				dest_offset_q <= '0;
			end else if (state_q == ST_TAIL) begin
				dest_offset_q <= dest_tail;
			end else begin
				dest_offset_q <= dest_slice;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign dest_offset  = dest_offset_q;
	assign data_byte    = data_byte_q;
	assign image_done   = image_done_q;

	`LSD_ASSERT_NEXT(a_result_follows, accept, result_valid, "accepted byte gave no result")
	`LSD_ASSERT_NOW(a_bytes_pending, state_q == ST_BYTES || state_q == ST_TAIL, bytes_left_q != '0, "taking bytes with none left in the image")
	`LSD_ASSERT_NEXT(a_cfg_restart, image_size_we && state_q != ST_CLEAR, state_q == ST_PLAN, "size write did not restart the image")

endmodule

// ----- tb/lcg_slice_descrambler_tb.sv -----
module lcg_slice_descrambler_tb;
	import lsd_pkg::*;

	localparam int STUCK_LIMIT = 400000;

	typedef struct {
		logic [SIZE_W-1:0] offset;
		logic [7:0]        data;
		logic              done;
	} byte_write_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              image_size_we = 1'b0;
	logic [SIZE_W-1:0] image_size = '0;
	logic              source_valid = 1'b0;
	logic [7:0]        source_byte = '0;
	logic              result_stall = 1'b0;
	logic              source_stall;
	logic              result_valid;
	logic [SIZE_W-1:0] dest_offset;
	logic [7:0]        data_byte;
	logic              image_done;

	lcg_slice_descrambler dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.image_size_we(image_size_we),
		.image_size   (image_size),
		.source_valid (source_valid),
		.source_stall (source_stall),
		.source_byte  (source_byte),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.dest_offset  (dest_offset),
		.data_byte    (data_byte),
		.image_done   (image_done)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// descrambler state as seen by the predictor
	logic [SIZE_W-1:0] cfg_size = '0;
	logic [15:0]       gen_seed = '0;
	logic [SIZE_W-1:0] bytes_left = '0;
	logic [4:0]        chunk_epoch = '0;
	logic [SIZE_W-1:0] chunk_base = '0;
	int                chunk_log = LOG_MAX_CHUNK;
	logic [15:0]       slice_idx = '0;
	logic [4:0]        byte_pos = '0;
	logic [15:0]       dest_slice = '0;
	logic              need_chunk = 1'b1;
	logic              in_tail = 1'b0;
	logic [15:0]       map_slot[int];
	logic [4:0]        map_tag[int];

	byte_write_t expected_writes[$];
	logic [7:0]  pending_bytes[$];
	byte_write_t due_write;
	int          error_count = 0;
	int          send_gap = 0;
	logic        send_burst = 1'b0;
	int          hold_left = 0;
	logic        recv_burst = 1'b0;
	int          stuck_cycles = 0;

	function automatic logic [15:0] map_lookup(input logic [15:0] idx);
		if (map_tag.exists(idx) && map_tag[idx] == chunk_epoch)
			return map_slot[idx];
		return idx;
	endfunction

	function automatic void map_store(input logic [15:0] idx, input logic [15:0] val);
		map_slot[idx] = val;
		map_tag[idx] = chunk_epoch;
	endfunction

	function automatic void descramble_byte(input logic [7:0] value);
		byte_write_t w;
		logic [15:0] swap_idx;
		logic [15:0] key;
		logic [15:0] ent_a;
		logic [15:0] ent_b;
		logic [SIZE_W-1:0] offset;
		if (bytes_left == 0) begin
			bytes_left = cfg_size;
			gen_seed = cfg_size[15:0];
			map_slot.delete();
			map_tag.delete();
			chunk_epoch = '0;
			chunk_base = '0;
			slice_idx = '0;
			byte_pos = '0;
			dest_slice = '0;
			need_chunk = 1'b1;
			in_tail = 1'b0;
		end
		if (bytes_left == 0) begin
			w.offset = '0;
			w.data = value;
			w.done = 1'b1;
			expected_writes.push_back(w);
			return;
		end
		if (need_chunk) begin
			in_tail = 1'b1;
			for (int k = LOG_MAX_CHUNK; k >= LOG_SLICE; k--) begin
				if ((32'd1 << k) <= 32'(bytes_left)) begin
					in_tail = 1'b0;
					chunk_log = k;
					chunk_epoch = chunk_epoch + 5'd1;
					slice_idx = 16'((32'd1 << (k - LOG_SLICE)) - 32'd1);
					break;
				end
			end
			byte_pos = '0;
			need_chunk = 1'b0;
		end
		if (in_tail) begin
			offset = chunk_base + SIZE_W'(byte_pos);
			byte_pos = byte_pos + 5'd1;
		end else begin
			if (byte_pos == 0) begin
				gen_seed = 16'((32'(gen_seed) * LCG_MUL + LCG_INC) & 32'h7fff);
				key = gen_seed + KEY_OFS;
				swap_idx = 16'((32'(slice_idx) * 32'(key)) >> 16);
				ent_a = map_lookup(slice_idx);
				ent_b = map_lookup(swap_idx);
				map_store(slice_idx, ent_b);
				map_store(swap_idx, ent_a);
				dest_slice = ent_b;
			end
			offset = chunk_base + (SIZE_W'(dest_slice) << LOG_SLICE) + SIZE_W'(byte_pos);
			if (byte_pos == 5'd31) begin
				if (slice_idx == 0) begin
					chunk_base = chunk_base + (SIZE_W'(1) << chunk_log);
					need_chunk = 1'b1;
				end else
					slice_idx = slice_idx - 16'd1;
			end
			byte_pos = byte_pos + 5'd1;
		end
		bytes_left = bytes_left - 1'b1;
		w.offset = offset;
		w.data = value;
		w.done = (bytes_left == 0);
		expected_writes.push_back(w);
	endfunction

	// source side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (source_valid && !source_stall)
				descramble_byte(source_byte);
			if (!source_valid || !source_stall) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					source_valid <= 1'b0;
				end else if (pending_bytes.size() != 0) begin
					source_valid <= 1'b1;
					source_byte <= pending_bytes.pop_front();
					send_gap <= send_burst ? 0 : $urandom_range(0, 8);
					if ($urandom_range(0, 63) == 0)
						send_burst <= !send_burst;
				end else
					source_valid <= 1'b0;
			end
		end
	end

	// result side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			hold_left = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_writes.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("unexpected transaction: dest_offset %h data_byte %h image_done %b",
							dest_offset, data_byte, image_done);
				end else begin
					due_write = expected_writes.pop_front();
					if (dest_offset !== due_write.offset || data_byte !== due_write.data ||
							image_done !== due_write.done) begin
						error_count++;
						if (error_count <= 10)
							$display("mismatch: exp %h/%h/%b got %h/%h/%b (offset/byte/done)",
								due_write.offset, due_write.data, due_write.done,
								dest_offset, data_byte, image_done);
					end
				end
				hold_left = recv_burst ? 0 : $urandom_range(0, 8);
				if ($urandom_range(0, 63) == 0)
					recv_burst = !recv_burst;
			end else if (result_valid && hold_left > 0)
				hold_left--;
			result_stall <= (hold_left > 0);
		end
	end

	// covers the epoch clearing pass after reset
	always @(posedge clk) begin
		if (!arst_n || (source_valid && !source_stall) || (result_valid && !result_stall))
			stuck_cycles <= 0;
		else if (stuck_cycles == STUCK_LIMIT) begin
			$display("[lcg_slice_descrambler] ERROR");
			$finish;
		end else
			stuck_cycles <= stuck_cycles + 1;
	end

	task automatic load_image_size(input logic [SIZE_W-1:0] size);
		@(posedge clk);
		image_size_we <= 1'b1;
		image_size <= size;
		cfg_size = size;
		bytes_left = '0;
		@(posedge clk);
		image_size_we <= 1'b0;
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_bytes.size() != 0 || source_valid || expected_writes.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic feed_bytes(input int count);
		repeat (count) pending_bytes.push_back(8'($urandom));
		wait_drained();
	endtask

	initial begin
		int total;
		int count;
		logic [SIZE_W-1:0] size;
		total = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// zero size, tail-only image with restart, largest size abandoned
		load_image_size('0);
		pending_bytes.push_back(8'h00);
		pending_bytes.push_back(8'hff);
		pending_bytes.push_back(8'h5a);
		wait_drained();
		load_image_size(SIZE_W'(5));
		feed_bytes(7);
		load_image_size({SIZE_W{1'b1}});
		feed_bytes(8);

		while (total < 1300) begin
			case ($urandom_range(0, 9))
				0: begin
					size = '0;
					count = $urandom_range(1, 4);
				end
				1: begin
					size = SIZE_W'($urandom_range(32'h200000, 32'hffffff));
					count = $urandom_range(1, 96);
				end
				2: begin
					size = SIZE_W'($urandom_range(1, 31));
					count = int'(size) * $urandom_range(1, 3) + $urandom_range(0, 5);
				end
				default: begin
					size = SIZE_W'($urandom_range(32, 600));
					case ($urandom_range(0, 3))
						0: count = $urandom_range(1, int'(size) - 1);
						1: count = int'(size) + $urandom_range(1, 40);
						default: count = int'(size);
					endcase
				end
			endcase
			load_image_size(size);
			feed_bytes(count);
			total += count;
		end

		repeat (8) @(posedge clk);
		if (expected_writes.size() != 0)
			error_count++;
		if (error_count == 0)
			$display("[lcg_slice_descrambler] OK");
		else
			$display("[lcg_slice_descrambler] ERROR");
		$finish;
	end

endmodule
